// File: src/avfc_pkg.sv
// shared types and constants for the alert volume fade controller
package avfc_pkg;

    localparam int          SEEN_DEPTH_DEF = 8;
    localparam logic [7:0]  NO_VOLUME      = 8'hFF;
    localparam logic [9:0]  MS_PER_SEC     = 10'd1000;

    // field widths
    localparam int TIME_W  = 32;
    localparam int VOL_W   = 8;
    localparam int FREQ_W  = 16;
    localparam int WIN_W   = 16;
    localparam int DLYMS_W = 18;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 24;
    localparam int CFG_W   = 16;

    // action codes
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_RESTORE = 2'd1,
        ACT_FADE    = 2'd2
    } t_action;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_DELAY    = 2'd1,
        CFG_FADE_VOL = 2'd2,
        CFG_WINDOW   = 2'd3
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEND,
        ST_TIME,
        ST_SCAN,
        ST_EVAL
    } t_state;

endpackage

// File: src/alert_volume_fade_controller.sv
// alert volume fade controller: poll sequencer, session state and result register
// A request passes the states PEND, TIME, SCAN and EVAL before its result is registered;
// SCAN steps through the frequencies held for the session (0 to SEEN_DEPTH) at one entry a cycle,
// and a table hit ends the scan early. A new request is taken only back in IDLE, after EVAL has
// written the result; a stalled result holds the sequencer in EVAL.
// Reset (synchronous, active low): config returns to off, 1 s, 0, 2000 ms; session and
// pending restore are cleared; the result register is emptied.
module alert_volume_fade_controller #(
    parameter int SEEN_DEPTH = avfc_pkg::SEEN_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // fields from bit 0: now_ms[31:0], has_alert[32], alert_muted[33],
    // alert_suppressed[34], current_volume[42:35], current_mute_volume[50:43],
    // alert_frequency[66:51], boost_active[67], boost_base_volume[75:68], zero pad
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [avfc_pkg::IN_W-1:0]   s_axis_tdata,
    // fields from bit 0: action[1:0], volume_out[9:2], mute_volume_out[17:10], zero pad
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [avfc_pkg::OUT_W-1:0]  m_axis_tdata,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [avfc_pkg::CFG_W-1:0]  i_cfg_data
);
    import avfc_pkg::*;

    localparam int IW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int CW = $clog2(SEEN_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(SEEN_DEPTH);

    // configuration registers
    logic                 r_fade_enable;
    logic [7:0]           r_fade_delay;
    logic [DLYMS_W-1:0]   r_delay_lim;
    logic [VOL_W-1:0]     r_fade_volume;
    logic [WIN_W-1:0]     r_window;

    // latched request
    logic [TIME_W-1:0]    r_now;
    logic                 r_has_alert, r_muted, r_suppressed, r_boost;
    logic [VOL_W-1:0]     r_cur, r_cur_mute, r_boost_base;
    logic [FREQ_W-1:0]    r_freq;

    // session and pending restore state
    logic                 r_sess_valid;
    logic [TIME_W-1:0]    r_sess_start;
    logic [VOL_W-1:0]     r_base_vol, r_base_mute;
    logic                 r_faded, r_fade_sent;
    logic [CW-1:0]        r_seen_count;
    logic [FREQ_W-1:0]    r_seen_table [SEEN_DEPTH];
    logic [VOL_W-1:0]     r_pend_vol, r_pend_mute;
    logic [TIME_W-1:0]    r_pend_time;

    // sequencer
    t_state               r_state, n_state;
    logic [CW-1:0]        r_idx;
    logic                 r_found, r_win_exp, r_time_ok;

    // result register
    logic                 r_out_valid;
    t_action              r_out_action;
    logic [VOL_W-1:0]     r_out_vol, r_out_mute;

    logic in_acc, eval_go, st_idle, st_pend, st_time, st_scan, st_eval;
    logic [TIME_W-1:0] unit_b, unit_lim, unit_diff;
    logic unit_gt, scan_live, scan_hit;

    // next values from the evaluation step
    logic                 n_sess_valid;
    logic [TIME_W-1:0]    n_sess_start;
    logic [VOL_W-1:0]     n_base_vol, n_base_mute;
    logic                 n_faded, n_fade_sent;
    logic [CW-1:0]        n_seen_count;
    logic                 n_seen_wr;
    logic [VOL_W-1:0]     n_pend_vol, n_pend_mute;
    logic [TIME_W-1:0]    n_pend_time;
    t_action              n_out_action;
    logic [VOL_W-1:0]     n_out_vol, n_out_mute;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = st_idle;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_mute, r_out_vol, r_out_action};
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // state decode
    always_comb begin
        st_idle = 1'b0;
        st_pend = 1'b0;
        st_time = 1'b0;
        st_scan = 1'b0;
        st_eval = 1'b0;
        unique case (r_state)
            ST_IDLE: st_idle = 1'b1;
            ST_PEND: st_pend = 1'b1;
            ST_TIME: st_time = 1'b1;
            ST_SCAN: st_scan = 1'b1;
            ST_EVAL: st_eval = 1'b1;
            default: st_idle = 1'b1;
        endcase
        eval_go = st_eval && (!r_out_valid || m_axis_tready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_PEND;
            ST_PEND: n_state = ST_TIME;
            ST_TIME: n_state = ST_SCAN;
            ST_SCAN: if (r_found || (r_idx >= r_seen_count)) n_state = ST_EVAL;
            ST_EVAL: if (eval_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_enable <= 1'b0;
            r_fade_delay  <= 8'd1;
            r_delay_lim   <= DLYMS_W'(MS_PER_SEC) - DLYMS_W'(1);
            r_fade_volume <= '0;
            r_window      <= WIN_W'(2000);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:   r_fade_enable <= i_cfg_data[0];
                CFG_DELAY: begin
                    r_fade_delay <= i_cfg_data[7:0];
                    r_delay_lim  <= DLYMS_W'(i_cfg_data[7:0]) * DLYMS_W'(MS_PER_SEC)
                                    - DLYMS_W'(1);
                end
                CFG_FADE_VOL: r_fade_volume <= i_cfg_data[7:0];
                CFG_WINDOW:   r_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now        <= s_axis_tdata[31:0];
            r_has_alert  <= s_axis_tdata[32];
            r_muted      <= s_axis_tdata[33];
            r_suppressed <= s_axis_tdata[34];
            r_cur        <= s_axis_tdata[42:35];
            r_cur_mute   <= s_axis_tdata[50:43];
            r_freq       <= s_axis_tdata[66:51];
            r_boost      <= s_axis_tdata[67];
            r_boost_base <= s_axis_tdata[75:68];
        end
    end

    // shared time unit: wrapped difference against a limit
    always_comb begin
        unit_b   = r_pend_time;
        unit_lim = TIME_W'(r_window);
        if (st_time) begin
            unit_b   = r_sess_valid ? r_sess_start : r_now;
            unit_lim = TIME_W'(r_delay_lim);
        end
        unit_diff = r_now - unit_b;
        unit_gt   = unit_diff > unit_lim;
    end

    // seen table compare, one entry per cycle
    assign scan_live = r_idx < r_seen_count;
    assign scan_hit  = scan_live && (r_seen_table[r_idx[IW-1:0]] == r_freq);

    always_ff @(posedge i_clk) begin
        if (st_pend) begin
            r_win_exp <= unit_gt;
            r_idx     <= '0;
            r_found   <= 1'b0;
        end
        if (st_time) begin
            r_time_ok <= (r_fade_delay == 8'd0) || unit_gt;
        end
        if (st_scan && scan_live) begin
            r_found <= r_found || scan_hit;
            r_idx   <= r_idx + CW'(1);
        end
    end

    // evaluation of one poll
    always_comb begin
        logic clr_pend, is_new, restore_ok, fade_sent_eff;
        clr_pend   = (r_pend_vol != NO_VOLUME) && ((r_cur == r_pend_vol) || r_win_exp);
        is_new     = (r_freq != '0) && !r_found;
        restore_ok = (r_base_vol != NO_VOLUME) && (r_cur != r_base_vol);

        n_sess_valid = r_sess_valid;
        n_sess_start = r_sess_start;
        n_base_vol   = r_base_vol;
        n_base_mute  = r_base_mute;
        n_faded      = r_faded;
        n_fade_sent  = r_fade_sent;
        n_seen_count = r_seen_count;
        n_seen_wr    = 1'b0;
        n_pend_vol   = clr_pend ? NO_VOLUME : r_pend_vol;
        n_pend_mute  = clr_pend ? '0 : r_pend_mute;
        n_pend_time  = clr_pend ? '0 : r_pend_time;
        n_out_action = ACT_NONE;
        n_out_vol    = '0;
        n_out_mute   = '0;
        fade_sent_eff = r_fade_sent;

        if (!r_fade_enable || !r_has_alert || r_muted || r_suppressed) begin
            // session ends, maybe with a restore
            if (r_fade_enable && (!r_has_alert || r_faded) && restore_ok) begin
                n_out_action = ACT_RESTORE;
                n_out_vol    = r_base_vol;
                n_out_mute   = r_base_mute;
                n_pend_vol   = r_base_vol;
                n_pend_mute  = r_base_mute;
                n_pend_time  = r_now;
            end
            if (!r_fade_enable) begin
                n_pend_vol  = NO_VOLUME;
                n_pend_mute = '0;
                n_pend_time = '0;
            end
            n_sess_valid = 1'b0;
            n_sess_start = '0;
            n_base_vol   = NO_VOLUME;
            n_base_mute  = '0;
            n_faded      = 1'b0;
            n_fade_sent  = 1'b0;
            n_seen_count = '0;
        end else if (r_faded && is_new) begin
            // new frequency while faded: restore and restart timer
            if (restore_ok) begin
                n_out_action = ACT_RESTORE;
                n_out_vol    = r_base_vol;
                n_out_mute   = r_base_mute;
                n_pend_vol   = r_base_vol;
                n_pend_mute  = r_base_mute;
                n_pend_time  = r_now;
            end
            n_sess_valid = 1'b1;
            n_sess_start = r_now;
            n_faded      = 1'b0;
            n_fade_sent  = 1'b0;
            if (r_seen_count < DEPTH_C) begin
                n_seen_wr    = 1'b1;
                n_seen_count = r_seen_count + CW'(1);
            end
        end else begin
            // session start
            if (!r_sess_valid) begin
                n_sess_valid = 1'b1;
                n_sess_start = r_now;
                if ((n_pend_vol != NO_VOLUME) && (r_cur < n_pend_vol)) begin
                    n_base_vol  = n_pend_vol;
                    n_base_mute = n_pend_mute;
                    n_pend_vol  = NO_VOLUME;
                    n_pend_mute = '0;
                    n_pend_time = '0;
                end else begin
                    n_base_vol  = (r_boost && (r_boost_base != NO_VOLUME)) ?
                                  r_boost_base : r_cur;
                    n_base_mute = r_cur_mute;
                end
                n_faded       = 1'b0;
                fade_sent_eff = 1'b0;
                n_seen_count  = '0;
                if (r_freq != '0) begin
                    n_seen_wr    = 1'b1;
                    n_seen_count = CW'(1);
                end
            end
            // fade once the delay has run out
            n_fade_sent = fade_sent_eff;
            if (!fade_sent_eff && r_time_ok) begin
                if (r_cur > r_fade_volume) begin
                    n_out_action = ACT_FADE;
                    n_out_vol    = r_fade_volume;
                    n_out_mute   = n_base_mute;
                    n_faded      = 1'b1;
                end
                n_fade_sent = 1'b1;
            end
        end
    end

    // session state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess_valid <= 1'b0;
            r_sess_start <= '0;
            r_base_vol   <= NO_VOLUME;
            r_base_mute  <= '0;
            r_faded      <= 1'b0;
            r_fade_sent  <= 1'b0;
            r_seen_count <= '0;
            r_pend_vol   <= NO_VOLUME;
            r_pend_mute  <= '0;
            r_pend_time  <= '0;
        end else if (eval_go) begin
            r_sess_valid <= n_sess_valid;
            r_sess_start <= n_sess_start;
            r_base_vol   <= n_base_vol;
            r_base_mute  <= n_base_mute;
            r_faded      <= n_faded;
            r_fade_sent  <= n_fade_sent;
            r_seen_count <= n_seen_count;
            r_pend_vol   <= n_pend_vol;
            r_pend_mute  <= n_pend_mute;
            r_pend_time  <= n_pend_time;
        end
    end

    // seen table write at the fill position
    always_ff @(posedge i_clk) begin
        if (eval_go && n_seen_wr) begin
            r_seen_table[(r_sess_valid && !(r_faded && r_freq != '0 && !r_found)) ?
                         IW'(0) : r_seen_count[IW-1:0]] <= r_freq;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eval_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_go) begin
            r_out_action <= n_out_action;
            r_out_vol    <= n_out_vol;
            r_out_mute   <= n_out_mute;
        end
    end

endmodule

// File: src/avfc_chk.sv
// port-level checks for the alert volume fade controller, bound to the top level
module avfc_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [avfc_pkg::OUT_W-1:0]  m_axis_tdata
);
    import avfc_pkg::*;

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // the sequencer is busy right after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted on back-to-back cycles");

    // only defined action codes
    a_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ACT_NONE) ||
                          (m_axis_tdata[1:0] == ACT_RESTORE) ||
                          (m_axis_tdata[1:0] == ACT_FADE))
        else $error("undefined action code");

    // no action carries zero volumes
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == ACT_NONE) |-> (m_axis_tdata[17:2] == '0))
        else $error("no-action result with non-zero volumes");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind alert_volume_fade_controller avfc_chk u_avfc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: verif/tb.sv
// testbench for the alert volume fade controller: directed table, then random polls vs a predictor
`timescale 1ns / 1ps

module tb;
    import avfc_pkg::*;

    localparam int SEEN_DEPTH = SEEN_DEPTH_DEF;
    localparam int SETTLE     = SEEN_DEPTH + 12;
    localparam int RUN_LIMIT  = 400000;

    // one status poll, now_ms in the lowest bits
    typedef struct packed {
        logic [7:0]  boost_base;
        logic        boost;
        logic [15:0] freq;
        logic [7:0]  cur_mute;
        logic [7:0]  cur;
        logic        sup;
        logic        mut;
        logic        alert;
        logic [31:0] now;
    } t_poll;

    typedef struct packed {
        t_action    act;
        logic [7:0] vol;
        logic [7:0] mute;
    } t_result;

    typedef struct {
        logic        is_cfg;
        t_cfg_idx    idx;
        logic [15:0] val;
        t_poll       p;
        logic        typed;
        t_result     want;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;

    alert_volume_fade_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor copy of registers and session state
    logic        en_r;
    logic [7:0]  delay_r;
    logic [7:0]  fvol_r;
    logic [15:0] window_r;
    logic        sess_on;
    logic [31:0] sess_t0;
    logic [7:0]  base_vol;
    logic [7:0]  base_mute;
    logic        faded_now;
    logic        fade_done;
    logic [3:0]  seen_n;
    logic [15:0] seen_freq [SEEN_DEPTH];
    logic [7:0]  rest_vol;
    logic [7:0]  rest_mute;
    logic [31:0] rest_t;

    t_result     due_actions [$];
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          send_pct = 0;
    int          stall_pct = 0;
    t_dir_row    rows [$];

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_cnt, msg);
        mismatch_cnt++;
    endtask

    task automatic drop_pending();
        rest_vol  = NO_VOLUME;
        rest_mute = 8'd0;
        rest_t    = 32'd0;
    endtask

    task automatic clear_sess();
        sess_on   = 1'b0;
        sess_t0   = 32'd0;
        base_vol  = NO_VOLUME;
        base_mute = 8'd0;
        faded_now = 1'b0;
        fade_done = 1'b0;
        seen_n    = 4'd0;
        foreach (seen_freq[i]) seen_freq[i] = 16'd0;
    endtask

    task automatic note_freq(input logic [15:0] f);
        if (seen_n < SEEN_DEPTH && f != 16'd0) begin
            seen_freq[seen_n] = f;
            seen_n = seen_n + 4'd1;
        end
    endtask

    // restore only when a baseline exists and differs from the volume now applied
    task automatic restore_if_needed(input t_poll p, inout t_result r);
        if (base_vol != NO_VOLUME && p.cur != base_vol) begin
            r.act     = ACT_RESTORE;
            r.vol     = base_vol;
            r.mute    = base_mute;
            rest_vol  = base_vol;
            rest_mute = base_mute;
            rest_t    = p.now;
        end
    endtask

    // expected action for one poll, advancing the predictor state
    task automatic fade_predict(input t_poll p, output t_result r);
        logic        fresh;
        logic [31:0] dly_ms;
        r.act  = ACT_NONE;
        r.vol  = 8'd0;
        r.mute = 8'd0;
        if (rest_vol != NO_VOLUME &&
            (p.cur == rest_vol || (p.now - rest_t) > {16'd0, window_r}))
            drop_pending();
        if (!en_r) begin
            clear_sess();
            drop_pending();
        end else if (!p.alert) begin
            restore_if_needed(p, r);
            clear_sess();
        end else if (p.mut || p.sup) begin
            if (faded_now) restore_if_needed(p, r);
            clear_sess();
        end else begin
            fresh = (p.freq != 16'd0);
            for (int i = 0; i < SEEN_DEPTH; i++)
                if (i < seen_n && seen_freq[i] == p.freq) fresh = 1'b0;
            if (faded_now && fresh) begin
                // new frequency while faded: restore and restart the timer
                restore_if_needed(p, r);
                sess_on   = 1'b1;
                sess_t0   = p.now;
                faded_now = 1'b0;
                fade_done = 1'b0;
                note_freq(p.freq);
            end else begin
                if (!sess_on) begin
                    sess_on = 1'b1;
                    sess_t0 = p.now;
                    if (rest_vol != NO_VOLUME && p.cur < rest_vol) begin
                        base_vol  = rest_vol;
                        base_mute = rest_mute;
                        drop_pending();
                    end else begin
                        base_vol  = (p.boost && p.boost_base != NO_VOLUME) ? p.boost_base
                                                                           : p.cur;
                        base_mute = p.cur_mute;
                    end
                    faded_now = 1'b0;
                    fade_done = 1'b0;
                    seen_n    = 4'd0;
                    note_freq(p.freq);
                end
                dly_ms = 32'(delay_r) * 32'(MS_PER_SEC);
                if (!fade_done && (p.now - sess_t0) >= dly_ms) begin
                    if (p.cur > fvol_r) begin
                        r.act     = ACT_FADE;
                        r.vol     = fvol_r;
                        r.mute    = base_mute;
                        faded_now = 1'b1;
                    end
                    fade_done = 1'b1;
                end
            end
        end
    endtask

    function automatic t_poll mk_poll(input logic [31:0] now, input int alert, input int mut,
                                      input int sup, input logic [7:0] cur,
                                      input logic [7:0] cur_mute, input logic [15:0] freq,
                                      input int boost, input logic [7:0] boost_base);
        t_poll p;
        p.now        = now;
        p.alert      = (alert != 0);
        p.mut        = (mut != 0);
        p.sup        = (sup != 0);
        p.cur        = cur;
        p.cur_mute   = cur_mute;
        p.freq       = freq;
        p.boost      = (boost != 0);
        p.boost_base = boost_base;
        return p;
    endfunction

    function automatic t_dir_row row_cfg(input t_cfg_idx idx, input logic [15:0] val);
        t_dir_row d;
        d.is_cfg = 1'b1;
        d.idx    = idx;
        d.val    = val;
        d.p      = '0;
        d.typed  = 1'b0;
        d.want   = '0;
        return d;
    endfunction

    function automatic t_dir_row row_poll(input t_poll p, input int typed, input t_action act,
                                          input logic [7:0] vol, input logic [7:0] mute);
        t_dir_row d;
        d.is_cfg    = 1'b0;
        d.idx       = CFG_ENABLE;
        d.val       = 16'd0;
        d.p         = p;
        d.typed     = (typed != 0);
        d.want.act  = act;
        d.want.vol  = vol;
        d.want.mute = mute;
        return d;
    endfunction

    // one register write request; valid stays high for the caller to lower
    task automatic cfg_write(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ENABLE:   en_r     = val[0];
            CFG_DELAY:    delay_r  = val[7:0];
            CFG_FADE_VOL: fvol_r   = val[7:0];
            CFG_WINDOW:   window_r = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // one poll request; the expectation is queued at its accept
    task automatic send_poll(input t_poll p, input logic typed, input t_result want,
                             output t_result calc);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(p);
        do @(posedge i_clk); while (!s_axis_tready);
        fade_predict(p, calc);
        due_actions.push_back(typed ? want : calc);
        @(negedge i_clk);
    endtask

    // drain all outstanding results, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (due_actions.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // receiver back-pressure
    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_actions.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, data %h",
                                          m_axis_tdata));
            end else begin
                want = due_actions.pop_front();
                if (m_axis_tdata[1:0] !== want.act || m_axis_tdata[9:2] !== want.vol ||
                    m_axis_tdata[17:10] !== want.mute)
                    report_mismatch($sformatf("action %0d/%0d vol %0d/%0d mute %0d/%0d",
                                              m_axis_tdata[1:0], want.act, m_axis_tdata[9:2],
                                              want.vol, m_axis_tdata[17:10], want.mute));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        logic        cfg_held;
        logic        in_alert;
        logic [7:0]  dev_vol;
        logic [7:0]  dev_mute;
        logic [15:0] pool [12];
        logic [15:0] cur_freq;
        logic [31:0] t_ms;
        logic [31:0] dly_ms;
        logic [95:0] raw;
        t_poll       p;
        t_result     calc;
        int          r;
        int          n_items;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_ENABLE;
        i_cfg_data    <= '0;
        en_r     = 1'b0;
        delay_r  = 8'd1;
        fvol_r   = 8'd0;
        window_r = 16'd2000;
        clear_sess();
        drop_pending();

        // directed table: session timing, new frequency, pending baseline, wrap, unknown volume
        rows.push_back(row_poll(mk_poll(32'd0, 1, 0, 0, 8'd200, 8'd10, 16'd440, 0, NO_VOLUME),
                                1, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_cfg(CFG_ENABLE, 16'd1));
        rows.push_back(row_cfg(CFG_FADE_VOL, 16'd50));
        rows.push_back(row_poll(mk_poll(32'd0, 1, 0, 0, 8'd200, 8'd10, 16'd440, 0, NO_VOLUME),
                                1, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'd999, 1, 0, 0, 8'd200, 8'd10, 16'd440, 0, NO_VOLUME),
                                1, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'd1000, 1, 0, 0, 8'd200, 8'd10, 16'd440, 0, NO_VOLUME),
                                1, ACT_FADE, 8'd50, 8'd10));
        rows.push_back(row_poll(mk_poll(32'd1500, 1, 0, 0, 8'd50, 8'd10, 16'd440, 0, NO_VOLUME),
                                1, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'd1600, 1, 0, 0, 8'd50, 8'd10, 16'd0, 0, NO_VOLUME),
                                1, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'd1700, 1, 0, 0, 8'd50, 8'd10, 16'd880, 0, NO_VOLUME),
                                1, ACT_RESTORE, 8'd200, 8'd10));
        rows.push_back(row_poll(mk_poll(32'd1800, 1, 0, 0, 8'd200, 8'd10, 16'd880, 0, NO_VOLUME),
                                0, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'd2700, 1, 0, 0, 8'd200, 8'd10, 16'd880, 0, NO_VOLUME),
                                0, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'd2800, 0, 0, 0, 8'd50, 8'd10, 16'd880, 0, NO_VOLUME),
                                1, ACT_RESTORE, 8'd200, 8'd10));
        rows.push_back(row_poll(mk_poll(32'd3000, 1, 0, 0, 8'd50, 8'd3, 16'd440, 0, NO_VOLUME),
                                0, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'd4000, 1, 0, 0, 8'd50, 8'd3, 16'd440, 0, NO_VOLUME),
                                1, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'd9000, 1, 1, 0, 8'd50, 8'd3, 16'd440, 0, NO_VOLUME),
                                1, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'hFFFF_FE00, 1, 0, 0, 8'd120, 8'd7, 16'd0, 1, 8'd180),
                                0, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'h0000_0200, 1, 0, 0, 8'd120, 8'd7, 16'd0, 0, NO_VOLUME),
                                1, ACT_FADE, 8'd50, 8'd7));
        rows.push_back(row_poll(mk_poll(32'h0000_0300, 1, 0, 1, 8'd50, 8'd7, 16'd0, 0, NO_VOLUME),
                                1, ACT_RESTORE, 8'd180, 8'd7));
        rows.push_back(row_poll(mk_poll(32'd2769, 0, 0, 0, 8'd50, 8'd7, 16'd0, 0, NO_VOLUME),
                                1, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'd100000, 1, 0, 0, NO_VOLUME, 8'd9, 16'd1, 1, NO_VOLUME),
                                1, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'd101000, 1, 0, 0, NO_VOLUME, 8'd9, 16'd1, 1, NO_VOLUME),
                                1, ACT_FADE, 8'd50, 8'd9));
        rows.push_back(row_poll(mk_poll(32'd101100, 0, 0, 0, 8'd50, 8'd9, 16'd1, 0, NO_VOLUME),
                                1, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'hFFFF_FFFF, 1, 1, 1, 8'hFF, 8'hFF, 16'hFFFF, 1, 8'hFF),
                                0, ACT_NONE, 8'd0, 8'd0));
        rows.push_back(row_poll(mk_poll(32'd0, 0, 0, 0, 8'd0, 8'd0, 16'd0, 0, 8'd0),
                                0, ACT_NONE, 8'd0, 8'd0));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        cfg_held = 1'b0;
        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                if (!cfg_held) wait_idle();
                cfg_write(rows[k].idx, rows[k].val);
                cfg_held = 1'b1;
            end else begin
                if (cfg_held) i_cfg_valid <= 1'b0;
                cfg_held = 1'b0;
                send_poll(rows[k].p, rows[k].typed, rows[k].want, calc);
            end
        end

        // random phases, each with its own register setting and one of four idling patterns
        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    cfg_write(CFG_ENABLE, 16'd1);
                    cfg_write(CFG_DELAY, 16'd0);
                    cfg_write(CFG_FADE_VOL, 16'd0);
                    cfg_write(CFG_WINDOW, 16'd0);
                end
                1: begin
                    cfg_write(CFG_ENABLE, 16'd1);
                    cfg_write(CFG_DELAY, 16'd255);
                    cfg_write(CFG_FADE_VOL, 16'd254);
                    cfg_write(CFG_WINDOW, 16'hFFFF);
                end
                default: begin
                    cfg_write(CFG_ENABLE, (ph == 3) ? 16'd0 : 16'd1);
                    cfg_write(CFG_DELAY, (ph == 8) ? 16'd0 : 16'($urandom_range(3)));
                    cfg_write(CFG_FADE_VOL, 16'($urandom_range(254)));
                    cfg_write(CFG_WINDOW, $urandom_range(1) ? 16'($urandom_range(3000))
                                                            : 16'($urandom_range(65535)));
                end
            endcase
            i_cfg_valid <= 1'b0;
            case (ph % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 50; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 50; end
                default: begin send_pct = 18; stall_pct = 18; end
            endcase
            foreach (pool[i]) pool[i] = 16'($urandom_range(65535, 1));
            pool[0]  = 16'hFFFF;
            pool[1]  = 16'h0001;
            cur_freq = pool[2];
            dev_vol  = 8'($urandom_range(255));
            dev_mute = 8'($urandom_range(255));
            in_alert = 1'b1;
            dly_ms   = 32'(delay_r) * 32'(MS_PER_SEC);
            t_ms     = (ph == 5) ? 32'hFFFF_0000 + $urandom_range(60000) : $urandom();
            n_items  = (ph == 3) ? 30 : 100;

            for (int n = 0; n < n_items; n++) begin
                // time moves on in small steps, with jumps that can pass the delay and rare random jumps
                r = $urandom_range(99);
                if (r < 2)       t_ms = $urandom();
                else if (r < 25) t_ms = t_ms + $urandom_range(dly_ms + 2500);
                else             t_ms = t_ms + $urandom_range(700);
                if ($urandom_range(99) < (in_alert ? 7 : 35)) begin
                    in_alert = !in_alert;
                    if (in_alert && $urandom_range(1)) dev_mute = 8'($urandom_range(255));
                end
                if ($urandom_range(99) < 8) begin
                    // noise: every field random, now_ms sometimes kept on the timeline
                    raw = {$urandom(), $urandom(), $urandom()};
                    p   = raw[$bits(t_poll)-1:0];
                    if ($urandom_range(1)) p.now = t_ms;
                    t_ms = p.now;
                end else begin
                    p.now   = t_ms;
                    p.alert = in_alert;
                    p.mut   = ($urandom_range(99) < 4);
                    p.sup   = ($urandom_range(99) < 4);
                    r = $urandom_range(99);
                    if (r < 50)      p.cur = dev_vol;
                    else if (r < 62) p.cur = base_vol;
                    else if (r < 70) p.cur = rest_vol;
                    else if (r < 80) p.cur = fvol_r + 8'($urandom_range(1));
                    else if (r < 85) p.cur = NO_VOLUME;
                    else begin
                        dev_vol = 8'($urandom_range(255));
                        p.cur   = dev_vol;
                    end
                    p.cur_mute = ($urandom_range(99) < 85) ? dev_mute : 8'($urandom_range(255));
                    if ($urandom_range(99) >= 55)
                        cur_freq = ($urandom_range(9) == 0) ? 16'd0 : pool[$urandom_range(11)];
                    p.freq       = cur_freq;
                    p.boost      = ($urandom_range(99) < 30);
                    p.boost_base = ($urandom_range(99) < 25) ? NO_VOLUME
                                                             : 8'($urandom_range(255));
                end
                send_poll(p, 1'b0, '0, calc);
                // the volume follows the requested action, as the firmware would apply it
                if (calc.act != ACT_NONE) dev_vol = calc.vol;
                if (send_pct != 0 && $urandom_range(99) < send_pct) begin
                    s_axis_tvalid <= 1'b0;
                    @(negedge i_clk);
                    while ($urandom_range(99) < send_pct) @(negedge i_clk);
                end
            end
        end

        wait_idle();
        if (mismatch_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: filelist.f
src/avfc_pkg.sv
src/alert_volume_fade_controller.sv
src/avfc_chk.sv
verif/tb.sv
